// ----- hw/rtl/mset_pkg.sv -----
// shared types and constants for the multi-slot event timer table
// no dependencies; imported by every module of the block

package mset_pkg;

  // default table depth and per-tick result limit
  localparam int NUM_SLOTS_DEF = 8;
  localparam int MAX_RESULTS   = 8;
  localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

  localparam int OPCODE_W   = 2;
  localparam int EVENT_W    = 8;
  localparam int DURATION_W = 32;
  localparam int ELAPSED_W  = 16;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SET    = 2'd0,
    OP_UNSET  = 2'd1,
    OP_TICK   = 2'd2,
    OP_CANCEL = 2'd3
  } op_t;

  // one entry of the slot store
  typedef struct packed {
    logic [EVENT_W-1:0]    event_id;
    logic [DURATION_W-1:0] duration;
    logic                  periodic;
    logic [DURATION_W-1:0] count;
  } slot_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // latch item fields and start the slot walk
    logic clear;  // free all slots
    logic flush;  // report the held result as the last one
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_done;  // final slot is being evaluated
  } dpath_stat_t;

endpackage

// ----- hw/rtl/mset_ctrl.sv -----
// controller state machine of the multi-slot event timer table
// depends on mset_pkg

module mset_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [mset_pkg::OPCODE_W-1:0] in_opcode,
  input  mset_pkg::dpath_stat_t      stat,
  output mset_pkg::ctrl_cmd_t        cmd,
  output logic                       busy
);
  import mset_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_CANCEL) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (stat.walk_done) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hw/rtl/mset_dpath.sv -----
// datapath of the multi-slot event timer table: slot store, walk pipeline,
// tick arithmetic and result register; depends on mset_pkg

module mset_dpath #(
  parameter int NUM_SLOTS = mset_pkg::NUM_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mset_pkg::ctrl_cmd_t              cmd,
  output mset_pkg::dpath_stat_t            stat,
  input  logic [mset_pkg::OPCODE_W-1:0]    in_opcode,
  input  logic [mset_pkg::EVENT_W-1:0]     in_event_id,
  input  logic [mset_pkg::DURATION_W-1:0]  in_duration_ms,
  input  logic                             in_periodic,
  input  logic [mset_pkg::ELAPSED_W-1:0]   in_elapsed,
  output logic                             out_strobe,
  output logic [mset_pkg::EVENT_W-1:0]     out_fired_event,
  output logic                             out_last_fired
);
  import mset_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  // slot store
  slot_t slot_mem [NUM_SLOTS];
  slot_t rd_data_r;
  logic  wr_en;
  slot_t wr_data;

  // latched item
  logic [OPCODE_W-1:0]   op_r;
  logic [EVENT_W-1:0]    id_r;
  logic [DURATION_W-1:0] dur_r;
  logic                  per_r;
  logic [ELAPSED_W-1:0]  elapsed_r;

  // walk pipeline
  logic             rd_act_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             ev_vld_r;
  logic [IDX_W-1:0] ev_idx_r;

  logic [NUM_SLOTS-1:0] used_r, used_nxt;
  logic [NUM_SLOTS-1:0] armed_r, armed_nxt;
  logic                 placed_r, placed_nxt;

  // result handling: one fired event is held until the next one shows or the flush
  logic               pend_vld_r, pend_vld_nxt;
  logic [EVENT_W-1:0] pend_ev_r, pend_ev_nxt;
  logic [CNT_W-1:0]   nres_r, nres_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  logic [EVENT_W-1:0] out_event_r, out_event_nxt;
  logic               out_last_r, out_last_nxt;

  // tick arithmetic
  logic                  slot_used, slot_armed;
  logic [DURATION_W:0]   sum;
  logic [DURATION_W-1:0] cnt_sat;
  logic [DURATION_W:0]   diff;
  logic                  fire;

  assign slot_used  = used_r[ev_idx_r];
  assign slot_armed = armed_r[ev_idx_r];

  assign sum     = {1'b0, rd_data_r.count} + {{(DURATION_W + 1 - ELAPSED_W){1'b0}}, elapsed_r};
  assign cnt_sat = sum[DURATION_W] ? '1 : sum[DURATION_W-1:0];
  assign diff    = {1'b0, cnt_sat} - {1'b0, rd_data_r.duration};
  assign fire    = !diff[DURATION_W];

  assign stat.walk_done = ev_vld_r && (ev_idx_r == LAST_IDX);

  always_comb begin
    used_nxt       = used_r;
    armed_nxt      = armed_r;
    placed_nxt     = placed_r;
    pend_vld_nxt   = pend_vld_r;
    pend_ev_nxt    = pend_ev_r;
    nres_nxt       = nres_r;
    out_strobe_nxt = 1'b0;
    out_event_nxt  = out_event_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_data        = rd_data_r;

    if (cmd.clear) begin
      used_nxt  = '0;
      armed_nxt = '0;
    end

    if (cmd.load) begin
      placed_nxt   = 1'b0;
      pend_vld_nxt = 1'b0;
      nres_nxt     = '0;
    end

    if (ev_vld_r) begin
      case (op_r)
        OP_SET: begin
          if (!slot_used && !placed_r) begin
            wr_en                = 1'b1;
            wr_data.event_id     = id_r;
            wr_data.duration     = dur_r;
            wr_data.periodic     = per_r;
            wr_data.count        = '0;
            used_nxt[ev_idx_r]   = 1'b1;
            armed_nxt[ev_idx_r]  = 1'b1;
            placed_nxt           = 1'b1;
          end
        end
        OP_UNSET: begin
          if (slot_used && rd_data_r.event_id == id_r) begin
            used_nxt[ev_idx_r]  = 1'b0;
            armed_nxt[ev_idx_r] = 1'b0;
          end
        end
        OP_TICK: begin
          if (slot_used && slot_armed) begin
            wr_en         = 1'b1;
            wr_data.count = cnt_sat;
            if (fire) begin
              if (rd_data_r.periodic) begin
                wr_data.count = diff[DURATION_W-1:0];
              end else begin
                armed_nxt[ev_idx_r] = 1'b0;
              end
              if (nres_r < CNT_W'(MAX_RESULTS)) begin
                if (pend_vld_r) begin
                  out_strobe_nxt = 1'b1;
                  out_event_nxt  = pend_ev_r;
                  out_last_nxt   = 1'b0;
                end
                pend_vld_nxt = 1'b1;
                pend_ev_nxt  = rd_data_r.event_id;
                nres_nxt     = nres_r + CNT_W'(1);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.flush && pend_vld_r) begin
      out_strobe_nxt = 1'b1;
      out_event_nxt  = pend_ev_r;
      out_last_nxt   = 1'b1;
      pend_vld_nxt   = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_act_r     <= 1'b0;
      rd_idx_r     <= '0;
      ev_vld_r     <= 1'b0;
      used_r       <= '0;
      armed_r      <= '0;
      placed_r     <= 1'b0;
      pend_vld_r   <= 1'b0;
      nres_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      used_r       <= used_nxt;
      armed_r      <= armed_nxt;
      placed_r     <= placed_nxt;
      pend_vld_r   <= pend_vld_nxt;
      nres_r       <= nres_nxt;
      out_strobe_r <= out_strobe_nxt;
      ev_vld_r     <= rd_act_r;
      if (cmd.load) begin
        rd_act_r <= 1'b1;
        rd_idx_r <= '0;
      end else if (rd_act_r) begin
        if (rd_idx_r == LAST_IDX) begin
          rd_act_r <= 1'b0;
        end else begin
          rd_idx_r <= rd_idx_r + IDX_W'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ev_idx_r    <= rd_idx_r;
    pend_ev_r   <= pend_ev_nxt;
    out_event_r <= out_event_nxt;
    out_last_r  <= out_last_nxt;
    if (cmd.load) begin
      op_r      <= in_opcode;
      id_r      <= in_event_id;
      dur_r     <= in_duration_ms;
      per_r     <= in_periodic;
      elapsed_r <= in_elapsed;
    end
  end

  // slot store: one write port at the evaluated slot, one read port ahead of it
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[ev_idx_r] <= wr_data;
    end
    rd_data_r <= slot_mem[rd_idx_r];
  end

  assign out_strobe      = out_strobe_r;
  assign out_fired_event = out_event_r;
  assign out_last_fired  = out_last_r;

endmodule

// ----- hw/rtl/multi_slot_event_timer_table.sv -----
// top level of the multi-slot event timer table
// depends on mset_pkg, mset_ctrl and mset_dpath

// Timer table with NUM_SLOTS slots. Issue an item by raising start while
// busy is low: opcode set places an id, duration and periodic flag in the
// lowest free slot (dropped when the table is full), unset frees every slot
// with a matching id, tick adds in_elapsed to each armed slot and reports
// the slots that expired, cancel frees the whole table. Cancel finishes at
// the accepting edge; set, unset and tick walk the slot store one slot per
// cycle, set by the single read port of the slot store, and busy stays high
// until the walk and the final flush are done. Expiries come out on
// out_fired_event with out_strobe high for exactly one cycle each, in slot
// order, at most eight per tick, the last one flagged by out_last_fired.
// The receiver cannot stall: every strobed result must be captured in its
// cycle. The last result of a tick is registered from the flush state, so
// it comes out after busy has fallen.

module multi_slot_event_timer_table #(
  parameter int NUM_SLOTS = mset_pkg::NUM_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [mset_pkg::OPCODE_W-1:0]    in_opcode,
  input  logic [mset_pkg::EVENT_W-1:0]     in_event_id,
  input  logic [mset_pkg::DURATION_W-1:0]  in_duration_ms,
  input  logic                             in_periodic,
  input  logic [mset_pkg::ELAPSED_W-1:0]   in_elapsed,
  output logic                             out_strobe,
  output logic [mset_pkg::EVENT_W-1:0]     out_fired_event,
  output logic                             out_last_fired
);
  import mset_pkg::*;

  // command and status between controller and datapath
  ctrl_cmd_t   cmd;
  dpath_stat_t stat;

  // sequencing: idle, slot walk, final result flush
  mset_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  // slot store, per-slot evaluation and result register
  mset_dpath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_opcode       (in_opcode),
    .in_event_id     (in_event_id),
    .in_duration_ms  (in_duration_ms),
    .in_periodic     (in_periodic),
    .in_elapsed      (in_elapsed),
    .out_strobe      (out_strobe),
    .out_fired_event (out_fired_event),
    .out_last_fired  (out_last_fired)
  );

endmodule
